// ===== rtl/jsld_pkg.sv =====
// Package for the JSON string literal decoder: phase and status codes,
// the result struct and the character lookup functions.
// Depends on nothing; used by jsld_step and json_string_literal_decoder.
`default_nettype none

package jsld_pkg;

    // Decoder phase.
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SPACE = 3'd1,
        PH_NULL  = 3'd2,
        PH_BODY  = 3'd3,
        PH_ESC   = 3'd4,
        PH_DONE  = 3'd5
    } t_phase;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_BYTE     = 3'd0,
        ST_COMPLETE = 3'd1,
        ST_ABSENT   = 3'd2,
        ST_NOQUOTE  = 3'd3,
        ST_BADESC   = 3'd4
    } t_status;

    // Characters the decoder recognises.
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_LOWER_L   = 8'h6C;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_U   = 8'h75;

    // Reset value of the null_as_absent register.
    localparam logic NULL_AS_ABSENT_RESET = 1'b0;

    // One decoded result, with a flag saying whether the byte produced one.
    typedef struct packed {
        logic       present;
        logic [7:0] out_byte;
        t_status    status;
        logic       last;
    } t_result;

    // Letter of the keyword null expected at a given match position.
    function automatic logic [7:0] null_letter(input logic [1:0] pos);
        logic [7:0] letter;
        unique case (pos)
            2'd0:    letter = CH_LOWER_N;
            2'd1:    letter = CH_LOWER_U;
            default: letter = CH_LOWER_L;
        endcase
        return letter;
    endfunction

    // Whitespace as skipped before a value: space, tab, LF, VT, FF and CR.
    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/jsld_step.sv =====
// Per-byte decoder: phase and null match registers plus the combinational
// decode of one text byte into at most one result.
// Depends on jsld_pkg.
`default_nettype none

module jsld_step (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_begin,
    input  wire logic              i_null_as_absent,
    output jsld_pkg::t_result      o_result
);

    jsld_pkg::t_phase r_phase, n_phase;
    logic [1:0]       r_count, n_count;

    jsld_pkg::t_phase phase_eff;
    logic [1:0]       count_eff;
    jsld_pkg::t_result res;

    // State registers advance only when a byte is consumed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= jsld_pkg::PH_IDLE;
            r_count <= 2'd0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    // Decode of one byte; a begin flag restarts at the whitespace phase.
    always_comb begin
        phase_eff    = i_begin ? jsld_pkg::PH_SPACE : r_phase;
        count_eff    = i_begin ? 2'd0 : r_count;
        n_phase      = phase_eff;
        n_count      = count_eff;
        res.present  = 1'b0;
        res.out_byte = 8'h00;
        res.status   = jsld_pkg::ST_BYTE;
        res.last     = 1'b0;

        unique case (phase_eff)
            jsld_pkg::PH_SPACE: begin
                if (jsld_pkg::is_space(i_byte)) begin
                    n_phase = jsld_pkg::PH_SPACE;
                end else if (i_byte == jsld_pkg::CH_LOWER_N) begin
                    n_count = 2'd1;
                    n_phase = jsld_pkg::PH_NULL;
                end else if (i_byte == jsld_pkg::CH_QUOTE) begin
                    n_phase = jsld_pkg::PH_BODY;
                end else begin
                    res.present = 1'b1;
                    res.status  = jsld_pkg::ST_NOQUOTE;
                    res.last    = 1'b1;
                end
            end
            jsld_pkg::PH_NULL: begin
                if (i_byte != jsld_pkg::null_letter(count_eff)) begin
                    res.present = 1'b1;
                    res.status  = jsld_pkg::ST_NOQUOTE;
                    res.last    = 1'b1;
                end else if (count_eff == 2'd3) begin
                    n_count     = 2'd0;
                    res.present = 1'b1;
                    res.status  = i_null_as_absent ? jsld_pkg::ST_ABSENT
                                                   : jsld_pkg::ST_COMPLETE;
                    res.last    = 1'b1;
                end else begin
                    n_count = count_eff + 2'd1;
                end
            end
            jsld_pkg::PH_BODY: begin
                if (i_byte == jsld_pkg::CH_NUL) begin
                    res.present = 1'b1;
                    res.status  = jsld_pkg::ST_NOQUOTE;
                    res.last    = 1'b1;
                end else if (i_byte == jsld_pkg::CH_BACKSLASH) begin
                    n_phase = jsld_pkg::PH_ESC;
                end else if (i_byte == jsld_pkg::CH_QUOTE) begin
                    res.present = 1'b1;
                    res.status  = jsld_pkg::ST_COMPLETE;
                    res.last    = 1'b1;
                end else begin
                    res.present  = 1'b1;
                    res.out_byte = i_byte;
                end
            end
            jsld_pkg::PH_ESC: begin
                n_phase     = jsld_pkg::PH_BODY;
                res.present = 1'b1;
                unique case (i_byte)
                    jsld_pkg::CH_LOWER_B:   res.out_byte = 8'h08;
                    jsld_pkg::CH_LOWER_F:   res.out_byte = 8'h0C;
                    jsld_pkg::CH_LOWER_N:   res.out_byte = 8'h0A;
                    jsld_pkg::CH_LOWER_R:   res.out_byte = 8'h0D;
                    jsld_pkg::CH_LOWER_T:   res.out_byte = 8'h09;
                    jsld_pkg::CH_QUOTE,
                    jsld_pkg::CH_SLASH,
                    jsld_pkg::CH_BACKSLASH: res.out_byte = i_byte;
                    jsld_pkg::CH_NUL: begin
                        res.status = jsld_pkg::ST_NOQUOTE;
                        res.last   = 1'b1;
                    end
                    default: begin
                        res.status = jsld_pkg::ST_BADESC;
                        res.last   = 1'b1;
                    end
                endcase
            end
            default: begin
                n_phase = phase_eff;
            end
        endcase

        // A finishing result parks the decoder until the next begin.
        if (res.last) begin
            n_phase = jsld_pkg::PH_DONE;
        end
    end

    assign o_result = res;

endmodule

`default_nettype wire

// ===== rtl/json_string_literal_decoder.sv =====
// JSON string literal decoder top level: input register, per-byte decode
// and result register. Depends on jsld_pkg and jsld_step.
// A byte is held in the input register, decoded, and its result registered in the result register.
// Throughput: one byte per cycle while the receiver does not stall the result register.
// Reset (synchronous, active low) empties both registers, returns to idle
// and clears null_as_absent.
`default_nettype none

module json_string_literal_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_data,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_begin_value,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic [2:0]      o_status,
    output logic            o_last
);

    logic              r_null_as_absent;
    logic              r_in_vld;
    logic [7:0]        r_in_byte;
    logic              r_in_begin;
    logic              r_out_vld;
    logic [7:0]        r_out_byte;
    logic [2:0]        r_out_status;
    logic              r_out_last;
    logic              out_free;
    logic              fire;
    jsld_pkg::t_result result;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_null_as_absent <= jsld_pkg::NULL_AS_ABSENT_RESET;
        end else if (i_cfg_we) begin
            r_null_as_absent <= i_cfg_data;
        end
    end

    // The held byte is decoded whenever the result register can take a result.
    assign out_free   = !r_out_vld || i_out_ready;
    assign fire       = r_in_vld && out_free;
    assign o_in_ready = !r_in_vld || out_free;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte  <= i_in_byte;
            r_in_begin <= i_begin_value;
        end
    end

    jsld_step u_step (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (fire),
        .i_byte           (r_in_byte),
        .i_begin          (r_in_begin),
        .i_null_as_absent (r_null_as_absent),
        .o_result         (result)
    );

    // Result register; a byte that yields no result leaves it empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= fire && result.present;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && result.present) begin
            r_out_byte   <= result.out_byte;
            r_out_status <= result.status;
            r_out_last   <= result.last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_byte  = r_out_byte;
    assign o_status    = r_out_status;
    assign o_last      = r_out_last;

endmodule

`default_nettype wire

// ===== test/json_string_literal_decoder_test.sv =====
// Self-checking testbench for json_string_literal_decoder: random and directed
// text values go in byte by byte, a scoreboard predicts every decoded result.
// Depends on jsld_pkg and the json_string_literal_decoder RTL.

module json_string_literal_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import jsld_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYCLE = 6;
    localparam int PHASE_BYTES  = 375;
    localparam int PRINT_CAP    = 50;

    // The keyword letters, first letter in the top byte.
    localparam logic [31:0] NULL_WORD = {CH_LOWER_N, CH_LOWER_U, CH_LOWER_L, CH_LOWER_L};

    // One decoded result as it leaves the block.
    typedef struct {
        logic [7:0] data;
        t_status    status;
        logic       fin;
    } decoded_t;

    // Scoreboard: tracks the decoder state and the results still owed.
    class string_decode_board;
        t_phase     phase_now;
        logic [1:0] matched;
        logic       null_absent;
        decoded_t   awaited[$];
        int         mismatches;
        int         checked;
        int         status_seen [5];

        function new();
            phase_now   = PH_IDLE;
            matched     = 2'd0;
            null_absent = NULL_AS_ABSENT_RESET;
            mismatches  = 0;
            checked     = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void await_result(logic [7:0] data, t_status status, logic fin);
            decoded_t r;
            r.data   = data;
            r.status = status;
            r.fin    = fin;
            awaited.push_back(r);
            if (fin) phase_now = PH_DONE;
        endfunction

        function bit is_blank(logic [7:0] c);
            return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        endfunction

        // Notes an accepted text byte; returns 1 unless the decoder ignores it.
        function bit take_text_byte(logic [7:0] c, logic restart);
            bit counted;
            if (restart) begin
                phase_now = PH_SPACE;
                matched   = 2'd0;
            end
            counted = (phase_now != PH_IDLE) && (phase_now != PH_DONE);
            case (phase_now)
                PH_SPACE: begin
                    if (c == CH_LOWER_N) begin
                        matched   = 2'd1;
                        phase_now = PH_NULL;
                    end else if (c == CH_QUOTE) begin
                        phase_now = PH_BODY;
                    end else if (!is_blank(c)) begin
                        await_result(8'h00, ST_NOQUOTE, 1'b1);
                    end
                end
                PH_NULL: begin
                    if (c != NULL_WORD[31 - 8 * matched -: 8]) begin
                        await_result(8'h00, ST_NOQUOTE, 1'b1);
                    end else if (matched == 2'd3) begin
                        matched = 2'd0;
                        await_result(8'h00, null_absent ? ST_ABSENT : ST_COMPLETE, 1'b1);
                    end else begin
                        matched = matched + 2'd1;
                    end
                end
                PH_BODY: begin
                    if (c == CH_NUL) await_result(8'h00, ST_NOQUOTE, 1'b1);
                    else if (c == CH_BACKSLASH) phase_now = PH_ESC;
                    else if (c == CH_QUOTE) await_result(8'h00, ST_COMPLETE, 1'b1);
                    else await_result(c, ST_BYTE, 1'b0);
                end
                PH_ESC: begin
                    // An escape always returns to the body unless it ends the value.
                    phase_now = PH_BODY;
                    case (c)
                        CH_LOWER_B: await_result(8'h08, ST_BYTE, 1'b0);
                        CH_LOWER_F: await_result(8'h0C, ST_BYTE, 1'b0);
                        CH_LOWER_N: await_result(8'h0A, ST_BYTE, 1'b0);
                        CH_LOWER_R: await_result(CH_CR, ST_BYTE, 1'b0);
                        CH_LOWER_T: await_result(CH_TAB, ST_BYTE, 1'b0);
                        CH_QUOTE, CH_SLASH, CH_BACKSLASH: await_result(c, ST_BYTE, 1'b0);
                        CH_NUL: await_result(8'h00, ST_NOQUOTE, 1'b1);
                        default: await_result(8'h00, ST_BADESC, 1'b1);
                    endcase
                end
                default: ;
            endcase
            return counted;
        endfunction

        task report_mismatch(string what, int got, int want);
            if (mismatches < PRINT_CAP)
                $display("Result %0d: %s is 0x%0h, expected 0x%0h", checked, what, got, want);
            mismatches++;
        endtask

        // Compares one accepted result with the oldest one awaited.
        task check_decoded(logic [7:0] data, logic [2:0] status, logic fin);
            decoded_t want;
            checked++;
            if (status <= ST_BADESC) status_seen[status]++;
            if (awaited.size() == 0) begin
                report_mismatch("unrequested result, status", status, 0);
                return;
            end
            want = awaited.pop_front();
            if (status != want.status) report_mismatch("status", status, want.status);
            if (data != want.data) report_mismatch("byte", data, want.data);
            if (fin != want.fin) report_mismatch("last", fin, want.fin);
        endtask
    endclass

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_we      = 1'b0;
    logic       i_cfg_data    = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic [7:0] i_in_byte     = 8'h00;
    logic       i_begin_value = 1'b0;
    logic       i_out_ready   = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic [2:0] o_status;
    logic       o_last;

    string_decode_board board = new();

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int phase_bytes = 0;
    int text_bytes = 0;
    int cycles = 0;
    bit fresh_value = 1'b0;

    json_string_literal_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .i_begin_value (i_begin_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_status      (o_status),
        .o_last        (o_last)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timed out with %0d results outstanding", board.awaited.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: check each accepted transaction, then pick the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_decoded(o_out_byte, o_status, o_last);
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offers one text byte and waits until the transaction is taken.
    task automatic send_text_byte(input logic [7:0] c, input logic restart);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_in_byte     <= c;
        i_begin_value <= restart;
        do @(posedge i_clk); while (!o_in_ready);
        text_bytes++;
        if (board.take_text_byte(c, restart)) phase_bytes++;
    endtask

    // Sends the next byte of the current value; the first one carries begin.
    task automatic feed(input logic [7:0] c);
        send_text_byte(c, fresh_value);
        fresh_value = 1'b0;
    endtask

    task automatic feed_text(input string s);
        for (int i = 0; i < s.len(); i++) feed(s[i]);
    endtask

    // Holds the sender off until every awaited result is back and the pipe is empty.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (board.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLE) @(posedge i_clk);
    endtask

    task automatic write_null_mode(input logic absent);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= absent;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.null_absent = absent;
    endtask

    function automatic logic [7:0] blank_byte();
        if ($urandom_range(5) == 0) return CH_SPACE;
        return 8'(CH_TAB + $urandom_range(4));
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BACKSLASH);
        return c;
    endfunction

    function automatic logic [7:0] escape_letter();
        case ($urandom_range(7))
            0: return CH_LOWER_B;
            1: return CH_LOWER_F;
            2: return CH_LOWER_N;
            3: return CH_LOWER_R;
            4: return CH_LOWER_T;
            5: return CH_QUOTE;
            6: return CH_SLASH;
            default: return CH_BACKSLASH;
        endcase
    endfunction

    // One random value: mostly well-formed strings and nulls, the rest broken.
    task automatic send_random_value();
        int kind;
        int count;
        fresh_value = 1'b1;
        kind = $urandom_range(99);
        if (kind < 70) repeat ($urandom_range(2)) feed(blank_byte());
        if (kind < 55) begin
            feed(CH_QUOTE);
            count = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
            repeat (count) begin
                if ($urandom_range(4) == 0) begin
                    feed(CH_BACKSLASH);
                    feed(escape_letter());
                end else begin
                    feed(plain_byte());
                end
            end
            feed(CH_QUOTE);
        end else if (kind < 70) begin
            feed_text("null");
            repeat ($urandom_range(2)) feed(8'($urandom_range(255)));
        end else if (kind < 78) begin
            // Keyword that may be cut short by some other byte.
            count = $urandom_range(3);
            for (int i = 0; i < count; i++) feed(NULL_WORD[31 - 8 * i -: 8]);
            feed(8'($urandom_range(255)));
        end else if (kind < 88) begin
            // String that may end in a bad escape or an early end of text.
            feed(CH_QUOTE);
            repeat ($urandom_range(3)) feed(plain_byte());
            if ($urandom_range(1)) feed(CH_BACKSLASH);
            feed($urandom_range(2) == 0 ? CH_NUL : 8'($urandom_range(255)));
        end else begin
            // Noise, with restarts anywhere.
            repeat ($urandom_range(1, 5)) begin
                if ($urandom_range(3) == 0) fresh_value = 1'b1;
                feed(8'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed values under the reset setting of null_as_absent.
        send_text_byte(8'hFF, 1'b0);
        fresh_value = 1'b1;
        feed_text(" \tnull");
        feed_text("x");
        fresh_value = 1'b1;
        feed(CH_QUOTE);
        feed(8'hFF);
        feed_text("\\/\\q");
        fresh_value = 1'b1;
        feed_text("nux");
        fresh_value = 1'b1;
        feed(CH_NUL);
        fresh_value = 1'b1;
        feed_text("\"\\");
        feed(CH_NUL);
        fresh_value = 1'b1;
        feed(CH_QUOTE);
        feed(CH_NUL);
        fresh_value = 1'b1;
        feed_text("\"a\"");

        // Random phases, each with its own handshake pressure and null setting.
        for (int p = 0; p < 4; p++) begin
            write_null_mode(p % 2 == 0);
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) send_random_value();
        end

        settle();
        $display("Sent %0d text bytes; checked %0d results: %0d content, %0d complete,",
                 text_bytes, board.checked, board.status_seen[ST_BYTE],
                 board.status_seen[ST_COMPLETE]);
        $display("%0d absent, %0d missing-quote and %0d bad-escape, over both null settings.",
                 board.status_seen[ST_ABSENT], board.status_seen[ST_NOQUOTE],
                 board.status_seen[ST_BADESC]);
        if (board.mismatches == 0 && board.awaited.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
